// ===== design/usg_pkg.sv =====
// Shared types, constants and helper functions of the UV sphere point generator.
package usg_pkg;

  localparam int CntW    = 9;
  localparam int RadW    = 16;
  localparam int IdxW    = 17;
  localparam int CoordW  = 17;
  localparam int PhW     = 32;
  localparam int CW      = 34;
  localparam int AngLen  = 24;

  // Divider shape: 32 quotient bits, four per stage
  localparam int DivPerStage = 4;
  localparam int DivStages   = PhW / DivPerStage;

  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [28:0]   CoordLimit = 29'sd65535;

  // atan(2^-k) in 2^-32 turn
  localparam logic [PhW-1:0] AngTable [AngLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_STACKS  = 2'd1,
    REG_SECTORS = 2'd2
  } usg_reg_e;

  typedef struct packed {
    logic [RadW-1:0] radius;
    logic [CntW-1:0] stacks;
    logic [CntW-1:0] sectors;
  } usg_cfg_t;

  // Classified grid point passed from front to back
  typedef struct packed {
    logic            oog;
    logic            first_valid;
    logic            second_valid;
    logic [IdxW-1:0] k1;
    logic [IdxW-1:0] k2;
    logic [CntW-1:0] row;
    logic [CntW-1:0] col;
  } usg_work_t;

  // One restoring division step: {quotient bit, new remainder}
  function automatic logic [CntW:0] div_step(logic [CntW-1:0] r, logic [CntW-1:0] d);
    logic [CntW:0] r2;
    r2 = {r, 1'b0};
    if (r2 >= {1'b0, d}) begin
      div_step = {1'b1, CntW'(r2 - {1'b0, d})};
    end else begin
      div_step = {1'b0, r2[CntW-1:0]};
    end
  endfunction

  // Fold a phase into [-1/4, 1/4) turn: {flip, signed angle}
  function automatic logic [CW:0] fold_phase(logic [PhW-1:0] p);
    logic            flip;
    logic [PhW-1:0]  sum;
    logic [PhW-1:0]  q;
    sum  = p + 32'h4000_0000;
    flip = sum[PhW-1];
    q    = flip ? (p ^ 32'h8000_0000) : p;
    fold_phase = {flip, {(CW-PhW){q[PhW-1]}}, q};
  endfunction

  // Clamp to the coordinate range
  function automatic logic signed [CoordW-1:0] sat_coord(logic signed [28:0] v);
    logic signed [28:0] c;
    if (v > CoordLimit) begin
      c = CoordLimit;
    end else if (v < -CoordLimit) begin
      c = -CoordLimit;
    end else begin
      c = v;
    end
    sat_coord = c[CoordW-1:0];
  endfunction

endpackage

// ===== design/usg_if.sv =====
// Valid/ready channel interfaces for grid points and sphere results.
interface usg_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] row_index;
  logic [8:0] column_index;

  modport source (output valid, row_index, column_index, input ready);
  modport sink   (input valid, row_index, column_index, output ready);
endinterface

interface usg_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic               first_tri_valid;
  logic [16:0]        first_tri_a;
  logic [16:0]        first_tri_b;
  logic [16:0]        first_tri_c;
  logic               second_tri_valid;
  logic [16:0]        second_tri_a;
  logic [16:0]        second_tri_b;
  logic [16:0]        second_tri_c;
  logic               point_out_of_grid;

  modport source (output valid, pos_x, pos_y, pos_z, first_tri_valid, first_tri_a,
                  first_tri_b, first_tri_c, second_tri_valid, second_tri_a,
                  second_tri_b, second_tri_c, point_out_of_grid, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, first_tri_valid, first_tri_a,
                  first_tri_b, first_tri_c, second_tri_valid, second_tri_a,
                  second_tri_b, second_tri_c, point_out_of_grid, output ready);
endinterface

// ===== design/uv_sphere_point_and_index_generator_core.sv =====
// UV sphere point and index generator: top level with the register port.
//
// Grid points (row_index, column_index) arrive as words on in_ch; each
// gives exactly one result word on out_ch with the vertex position, x and y
// in signed Q8.8 and z in signed Q0.16, and up to two triangles of vertex indices.
// Radius, stack count and sector count sit in APB registers at byte
// addresses 0, 4 and 8; write them only while no point is in flight.
// Throughput is one point per cycle while the receiver does not stall. From
// input acceptance to the result word the pipe holds one stage that splits off the
// integer quotient bit as the word leaves the front queue, an eight-stage
// phase divider (four quotient bits per stage), one fold stage, one CORDIC
// stage per step, three multiply/round stages and the output register.
// A two-word queue parts the front end from the back end, so input is
// taken while a result waits. When the receiver stalls, the back pipe
// holds in place and the queue fills; in_ch.ready drops once it is full.
// Reset empties the queue and pipe and loads radius 1.0, 16 stacks and
// 16 sectors.
module uv_sphere_point_and_index_generator_core #(
  parameter int MAX_STACKS   = 256,
  parameter int MAX_SECTORS  = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  usg_in_if.sink      in_ch,
  usg_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import usg_pkg::*;

  usg_cfg_t  cfg_q;
  usg_work_t front_work, fifo_work;
  logic      push, fifo_full, fifo_valid, pop;
  logic      wr_en;
  usg_reg_e  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = usg_reg_e'(paddr[3:2]);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius  <= 16'd256;
      cfg_q.stacks  <= 9'd16;
      cfg_q.sectors <= 9'd16;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RADIUS:  cfg_q.radius  <= pwdata[RadW-1:0];
        REG_STACKS:  cfg_q.stacks  <= pwdata[CntW-1:0];
        REG_SECTORS: cfg_q.sectors <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_sel)
      REG_RADIUS:  prdata = {16'd0, cfg_q.radius};
      REG_STACKS:  prdata = {23'd0, cfg_q.stacks};
      REG_SECTORS: prdata = {23'd0, cfg_q.sectors};
      default:     prdata = '0;
    endcase
  end

  usg_front #(
    .MAX_STACKS  (MAX_STACKS),
    .MAX_SECTORS (MAX_SECTORS)
  ) u_front (
    .cfg_i       (cfg_q),
    .in_ch       (in_ch),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .work_o      (front_work)
  );

  usg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .data_o  (fifo_work)
  );

  usg_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .work_valid_i (fifo_valid),
    .work_i       (fifo_work),
    .work_pop_o   (pop),
    .out_ch       (out_ch)
  );

endmodule

// ===== design/usg_front.sv =====
// Front end: accepts grid points, checks the grid and builds triangle indices.
module usg_front #(
  parameter int MAX_STACKS  = 256,
  parameter int MAX_SECTORS = 256
) (
  input  usg_pkg::usg_cfg_t  cfg_i,
  usg_in_if.sink             in_ch,
  input  logic               fifo_full_i,
  output logic               push_o,
  output usg_pkg::usg_work_t work_o
);
  import usg_pkg::*;

  logic [CntW-1:0] row, col, t_cnt, s_cnt;
  logic            bad_cnt, oog, in_tri;
  logic [18:0]     k1_w, k2_w;

  assign row   = in_ch.row_index;
  assign col   = in_ch.column_index;
  assign t_cnt = cfg_i.stacks;
  assign s_cnt = cfg_i.sectors;

  // Take a word whenever the queue has room
  assign in_ch.ready = !fifo_full_i;
  assign push_o      = in_ch.valid && !fifo_full_i;

  // Classify the point against the grid
  assign bad_cnt = (t_cnt == '0) || (32'(t_cnt) > 32'(MAX_STACKS)) ||
                   (s_cnt == '0) || (32'(s_cnt) > 32'(MAX_SECTORS));
  assign oog     = bad_cnt || (row > t_cnt) || (col > s_cnt);
  assign in_tri  = !oog && (row < t_cnt) && (col < s_cnt);

  // k1 = i*(S+1)+j, k2 = k1+S+1
  assign k1_w = 19'(row) * 19'(s_cnt) + 19'(row) + 19'(col);
  assign k2_w = k1_w + 19'(s_cnt) + 19'd1;

  always_comb begin
    work_o.oog          = oog;
    work_o.first_valid  = in_tri && (row != '0);
    work_o.second_valid = in_tri && (row != CntW'(t_cnt - 9'd1));
    work_o.k1           = k1_w[IdxW-1:0];
    work_o.k2           = k2_w[IdxW-1:0];
    work_o.row          = row;
    work_o.col          = col;
  end

endmodule

// ===== design/usg_fifo.sv =====
// Two-entry queue between the front end and the arithmetic back end.
module usg_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  usg_pkg::usg_work_t data_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output usg_pkg::usg_work_t data_o
);
  import usg_pkg::*;

  usg_work_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  // Store pushed words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== design/usg_back.sv =====
// Back end: phase division, two CORDIC pipes, scaling and the output register.
module usg_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  usg_pkg::usg_cfg_t  cfg_i,
  input  logic               work_valid_i,
  input  usg_pkg::usg_work_t work_i,
  output logic               work_pop_o,
  usg_out_if.source          out_ch
);
  import usg_pkg::*;

  localparam int CordBase = DivStages + 2;
  localparam int M1Idx    = CordBase + CORDIC_STEPS;
  localparam int Depth    = M1Idx + 3;

  logic             advance;
  logic             out_valid_q;
  logic [Depth-1:0] valid_q;
  usg_work_t        tag_q [Depth];

  // Whole pipe moves when the output register is free
  assign advance    = !out_valid_q || out_ch.ready;
  assign work_pop_o = work_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[Depth-2:0], work_pop_o};
    end
  end

  // Carry the classified word alongside the arithmetic
  for (genvar i = 0; i < Depth; i++) begin : g_tag
    always_ff @(posedge clk_i) begin
      if (advance) begin
        tag_q[i] <= (i == 0) ? work_i : tag_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // ---------------- phase division ----------------
  logic [CntW-1:0] rems_q [DivStages+1];
  logic [CntW-1:0] remt_q [DivStages+1];
  logic [PhW-1:0]  qs_q   [DivStages+1];
  logic [PhW-1:0]  qt_q   [DivStages+1];
  logic            qht_q  [DivStages+1];

  // Split off the integer quotient bit
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rems_q[0] <= (work_i.col >= cfg_i.sectors) ? CntW'(work_i.col - cfg_i.sectors)
                                                 : work_i.col;
      remt_q[0] <= (work_i.row >= cfg_i.stacks) ? CntW'(work_i.row - cfg_i.stacks)
                                                : work_i.row;
      qht_q[0]  <= (work_i.row >= cfg_i.stacks);
      qs_q[0]   <= '0;
      qt_q[0]   <= '0;
    end
  end

  for (genvar n = 0; n < DivStages; n++) begin : g_div
    logic [CntW-1:0] rs, rt;
    logic [PhW-1:0]  qs, qt;
    logic [CntW:0]   ss, st;

    // Four restoring steps per stage
    always_comb begin
      rs = rems_q[n];
      rt = remt_q[n];
      qs = qs_q[n];
      qt = qt_q[n];
      ss = '0;
      st = '0;
      for (int b = 0; b < DivPerStage; b++) begin
        ss = div_step(rs, cfg_i.sectors);
        st = div_step(rt, cfg_i.stacks);
        qs = {qs[PhW-2:0], ss[CntW]};
        qt = {qt[PhW-2:0], st[CntW]};
        rs = ss[CntW-1:0];
        rt = st[CntW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rems_q[n+1] <= rs;
        remt_q[n+1] <= rt;
        qs_q[n+1]   <= qs;
        qt_q[n+1]   <= qt;
        qht_q[n+1]  <= qht_q[n];
      end
    end
  end

  // ---------------- CORDIC, lane 0 stack, lane 1 sector ----------------
  logic signed [CW-1:0] cx_q [CORDIC_STEPS+1][2];
  logic signed [CW-1:0] cy_q [CORDIC_STEPS+1][2];
  logic signed [CW-1:0] cz_q [CORDIC_STEPS+1][2];
  logic                 cf_q [CORDIC_STEPS+1][2];

  logic [PhW-1:0] stk_ph, sec_ph;
  logic [CW:0]    stk_f, sec_f;

  // Form the phases and fold them into the CORDIC range
  assign sec_ph = qs_q[DivStages];
  assign stk_ph = 32'h4000_0000 - {qht_q[DivStages], qt_q[DivStages][PhW-1:1]};
  assign stk_f  = fold_phase(stk_ph);
  assign sec_f  = fold_phase(sec_ph);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cx_q[0][0] <= CordicGain;
      cy_q[0][0] <= '0;
      cz_q[0][0] <= $signed(stk_f[CW-1:0]);
      cf_q[0][0] <= stk_f[CW];
      cx_q[0][1] <= CordicGain;
      cy_q[0][1] <= '0;
      cz_q[0][1] <= $signed(sec_f[CW-1:0]);
      cf_q[0][1] <= sec_f[CW];
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cord
    for (genvar c = 0; c < 2; c++) begin : g_lane
      logic signed [CW-1:0] dx, dy, ang;
      assign dx  = cy_q[k][c] >>> k;
      assign dy  = cx_q[k][c] >>> k;
      assign ang = $signed({{(CW-PhW){1'b0}}, AngTable[k]});

      // Rotate toward zero residual angle
      always_ff @(posedge clk_i) begin
        if (advance) begin
          if (!cz_q[k][c][CW-1]) begin
            cx_q[k+1][c] <= cx_q[k][c] - dx;
            cy_q[k+1][c] <= cy_q[k][c] + dy;
            cz_q[k+1][c] <= cz_q[k][c] - ang;
          end else begin
            cx_q[k+1][c] <= cx_q[k][c] + dx;
            cy_q[k+1][c] <= cy_q[k][c] - dy;
            cz_q[k+1][c] <= cz_q[k][c] + ang;
          end
          cf_q[k+1][c] <= cf_q[k][c];
        end
      end
    end
  end

  // ---------------- scaling ----------------
  logic signed [CW-1:0] cst, sst, csc, ssc;
  logic signed [50:0]   pxy_q, pz_q, rxy, rz;
  logic signed [CW-1:0] csc1_q, ssc1_q, csc2_q, ssc2_q;
  logic signed [28:0]   xy_q, z2_q, z3_q;
  logic signed [62:0]   px_q, py_q, rx, ry;

  assign cst = cf_q[CORDIC_STEPS][0] ? -cx_q[CORDIC_STEPS][0] : cx_q[CORDIC_STEPS][0];
  assign sst = cf_q[CORDIC_STEPS][0] ? -cy_q[CORDIC_STEPS][0] : cy_q[CORDIC_STEPS][0];
  assign csc = cf_q[CORDIC_STEPS][1] ? -cx_q[CORDIC_STEPS][1] : cx_q[CORDIC_STEPS][1];
  assign ssc = cf_q[CORDIC_STEPS][1] ? -cy_q[CORDIC_STEPS][1] : cy_q[CORDIC_STEPS][1];

  assign rxy = pxy_q + 51'sd2097152;
  assign rz  = pz_q + 51'sd2097152;
  assign rx  = px_q + 63'sd137438953472;
  assign ry  = py_q + 63'sd137438953472;

  // Radius times stack cosine and sine, round to Q8.16, then ring scaling
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pxy_q  <= $signed({1'b0, cfg_i.radius}) * cst;
      pz_q   <= $signed({1'b0, cfg_i.radius}) * sst;
      csc1_q <= csc;
      ssc1_q <= ssc;
      xy_q   <= rxy[50:22];
      z2_q   <= rz[50:22];
      csc2_q <= csc1_q;
      ssc2_q <= ssc1_q;
      px_q   <= xy_q * csc2_q;
      py_q   <= xy_q * ssc2_q;
      z3_q   <= z2_q;
    end
  end

  // ---------------- output register ----------------
  usg_work_t          tg;
  logic signed [16:0] pos_x_q, pos_y_q, pos_z_q;
  logic               f_v_q, s_v_q, oog_q;
  logic [IdxW-1:0]    fa_q, fb_q, fc_q, sa_q, sb_q, sc_q;

  assign tg = tag_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_q[Depth-1];
    end
  end

  // Round, clamp and zero what the grid check rules out
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pos_x_q <= tg.oog ? '0 : sat_coord($signed({{4{rx[62]}}, rx[62:38]}));
      pos_y_q <= tg.oog ? '0 : sat_coord($signed({{4{ry[62]}}, ry[62:38]}));
      pos_z_q <= tg.oog ? '0 : sat_coord(z3_q);
      oog_q   <= tg.oog;
      f_v_q   <= tg.first_valid;
      fa_q    <= tg.first_valid ? tg.k1 : '0;
      fb_q    <= tg.first_valid ? tg.k2 : '0;
      fc_q    <= tg.first_valid ? IdxW'(tg.k1 + 17'd1) : '0;
      s_v_q   <= tg.second_valid;
      sa_q    <= tg.second_valid ? IdxW'(tg.k1 + 17'd1) : '0;
      sb_q    <= tg.second_valid ? tg.k2 : '0;
      sc_q    <= tg.second_valid ? IdxW'(tg.k2 + 17'd1) : '0;
    end
  end

  assign out_ch.valid             = out_valid_q;
  assign out_ch.pos_x             = pos_x_q;
  assign out_ch.pos_y             = pos_y_q;
  assign out_ch.pos_z             = pos_z_q;
  assign out_ch.first_tri_valid   = f_v_q;
  assign out_ch.first_tri_a       = fa_q;
  assign out_ch.first_tri_b       = fb_q;
  assign out_ch.first_tri_c       = fc_q;
  assign out_ch.second_tri_valid  = s_v_q;
  assign out_ch.second_tri_a      = sa_q;
  assign out_ch.second_tri_b      = sb_q;
  assign out_ch.second_tri_c      = sc_q;
  assign out_ch.point_out_of_grid = oog_q;

endmodule

// ===== design/usg_sva.sv =====
// Port-level assertions for the UV sphere generator, bound to the top level.
module usg_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [16:0] pos_x_i,
  input logic [16:0] pos_y_i,
  input logic [16:0] pos_z_i,
  input logic        first_valid_i,
  input logic [16:0] first_a_i,
  input logic [16:0] first_c_i,
  input logic        second_valid_i,
  input logic [16:0] second_a_i,
  input logic        oog_i
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // Drop triangles and position for a point off the grid
  a_oog_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && oog_i |-> !first_valid_i && !second_valid_i &&
    pos_x_i == 17'd0 && pos_y_i == 17'd0 && pos_z_i == 17'd0)
    else $error("off-grid point carries data");

  // First triangle closes on the next vertex of its row
  a_first_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && first_valid_i |-> first_c_i == 17'(first_a_i + 17'd1))
    else $error("first triangle corner mismatch");

  // Both triangles share the k1+1 corner
  a_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && first_valid_i && second_valid_i |-> second_a_i == first_c_i)
    else $error("triangles do not share a corner");

endmodule

bind uv_sphere_point_and_index_generator_core usg_sva u_usg_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_ch.valid),
  .out_ready_i    (out_ch.ready),
  .pos_x_i        (out_ch.pos_x),
  .pos_y_i        (out_ch.pos_y),
  .pos_z_i        (out_ch.pos_z),
  .first_valid_i  (out_ch.first_tri_valid),
  .first_a_i      (out_ch.first_tri_a),
  .first_c_i      (out_ch.first_tri_c),
  .second_valid_i (out_ch.second_tri_valid),
  .second_a_i     (out_ch.second_tri_a),
  .oog_i          (out_ch.point_out_of_grid)
);
